>>> src/aekd_pkg.sv
// Package for the ANSI escape key decoder: item and command types, character
// and keypad constants, key lookup functions. No dependencies.
`default_nettype none

package aekd_pkg;

  // Input item operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_IDLE = 1'b1;

  // Characters of interest
  localparam logic [7:0] ESC_BYTE = 8'd27;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_SS3 = 8'h4f;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_F = 8'h46;

  // Keypad codes
  localparam logic [7:0] KEY_UP = 8'h38;
  localparam logic [7:0] KEY_DOWN = 8'h32;
  localparam logic [7:0] KEY_RIGHT = 8'h36;
  localparam logic [7:0] KEY_LEFT = 8'h34;
  localparam logic [7:0] KEY_HOME = 8'h37;
  localparam logic [7:0] KEY_END = 8'h31;
  localparam logic [7:0] KEY_INS = 8'h30;
  localparam logic [7:0] KEY_DEL = 8'h2e;
  localparam logic [7:0] KEY_PGUP = 8'h39;
  localparam logic [7:0] KEY_PGDN = 8'h33;

  localparam logic [15:0] TIMEOUT_RESET = 16'd8000;
  localparam logic [2:0] ARG_INDEX_MAX = 3'd7;
  localparam logic [7:0] ARG_SAT = 8'd255;

  typedef struct packed {
    logic       operation;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_CSI    = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ESC_START,
    ACT_PASS,
    ACT_TIMEOUT,
    ACT_TICK,
    ACT_OPEN,
    ACT_DIGIT,
    ACT_SEP,
    ACT_KEY,
    ACT_DROP,
    ACT_REPLAY
  } action_t;

  typedef enum logic {
    CMD_EMIT,
    CMD_REPLAY
  } cmd_kind_t;

  // Front to back command. EMIT: one result, code. REPLAY: raw bytes from
  // the buffer, then code as a tail result when has_tail is set.
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] code;
    logic       has_tail;
  } cmd_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_RUN,
    BS_TAIL
  } back_state_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } key_lookup_t;

  function automatic key_lookup_t final_key(input logic [7:0] b);
    key_lookup_t r;
    r.hit = 1'b1;
    unique case (b)
      CH_A: r.code = KEY_UP;
      CH_B: r.code = KEY_DOWN;
      CH_C: r.code = KEY_RIGHT;
      CH_D: r.code = KEY_LEFT;
      CH_H: r.code = KEY_HOME;
      CH_F: r.code = KEY_END;
      default: begin
        r.hit  = 1'b0;
        r.code = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic key_lookup_t tilde_key(input logic [7:0] a);
    key_lookup_t r;
    r.hit = 1'b1;
    unique case (a)
      8'd1, 8'd7: r.code = KEY_HOME;
      8'd2:       r.code = KEY_INS;
      8'd3:       r.code = KEY_DEL;
      8'd4, 8'd8: r.code = KEY_END;
      8'd5:       r.code = KEY_PGUP;
      8'd6:       r.code = KEY_PGDN;
      default: begin
        r.hit  = 1'b0;
        r.code = 8'h00;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/aekd_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
`default_nettype none

module aekd_ram #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

>>> src/aekd_cmdq.sv
// Two-entry command queue between front and back.
// No package dependency; width set by parameter.
`default_nettype none

module aekd_cmdq #(
  parameter int unsigned W = 15
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic      [W-1:0] rdata,
  output logic              empty
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;
  logic         do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> src/aekd_front.sv
// Front end: accepts input beats, runs the escape parser, fills the sequence
// buffer and posts commands. Depends on aekd_pkg.
`default_nettype none

module aekd_front #(
  parameter int unsigned BUFFER_DEPTH = 32,
  localparam int unsigned AW = $clog2(BUFFER_DEPTH),
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire aekd_pkg::in_item_t in_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data,
  output logic                    ram_we,
  output logic [AW-1:0]           ram_waddr,
  output logic [7:0]              ram_wdata,
  output logic                    q_push,
  input  wire logic               q_full,
  output aekd_pkg::cmd_t          q_cmd,
  output logic [AW-1:0]           q_last_idx,
  input  wire logic               replay_done
);

  aekd_pkg::mode_t   mode_r, mode_nxt;
  aekd_pkg::action_t act;
  logic [15:0]       idle_cnt_r, idle_cnt_nxt;
  logic [15:0]       timeout_r;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [2:0]        arg_idx_r, arg_idx_nxt;
  logic [7:0]        first_arg_r, first_arg_nxt;
  logic [7:0]        last_byte_r, last_byte_nxt;
  logic              wait_r, wait_nxt;

  logic              accept, is_byte, room, is_digit, rep_esc;
  logic [7:0]        b, last_eff, key_code;
  logic [CW-1:0]     fill_eff, cnt_m2;
  logic [11:0]       arg_acc;
  aekd_pkg::key_lookup_t key_lu, tilde_lu;

  // Stall on a full queue, while a replay still reads the buffer, and in reset
  assign full      = q_full | wait_r | ~rst_n;
  assign accept    = push & ~full;
  assign cfg_ready = rst_n;

  assign b        = in_item.byte_value;
  assign is_byte  = (in_item.operation == aekd_pkg::OP_BYTE);
  assign room     = (fill_r < CW'(BUFFER_DEPTH));
  assign fill_eff = room ? fill_r + CW'(1) : fill_r;
  assign last_eff = room ? b : last_byte_r;
  assign cnt_m2   = fill_eff - CW'(2);
  assign rep_esc  = (last_eff == aekd_pkg::ESC_BYTE);
  assign is_digit = (b >= aekd_pkg::CH_0) && (b <= aekd_pkg::CH_9);
  assign key_lu   = aekd_pkg::final_key(b);
  assign tilde_lu = aekd_pkg::tilde_key(first_arg_r);
  assign key_code = (b == aekd_pkg::CH_TILDE) ? tilde_lu.code : key_lu.code;
  assign arg_acc  = 12'(first_arg_r) * 12'd10 + {8'd0, b[3:0]};

  // Classify the beat
  always_comb begin
    act = aekd_pkg::ACT_NONE;
    if (accept) begin
      unique case (mode_r)
        aekd_pkg::MODE_ESC: begin
          if (!is_byte) begin
            act = (idle_cnt_r >= timeout_r) ? aekd_pkg::ACT_TIMEOUT : aekd_pkg::ACT_TICK;
          end else if (b == aekd_pkg::CH_LBRACK || b == aekd_pkg::CH_SS3) begin
            act = aekd_pkg::ACT_OPEN;
          end else begin
            act = aekd_pkg::ACT_REPLAY;
          end
        end
        aekd_pkg::MODE_CSI: begin
          priority if (!is_byte) begin
            act = aekd_pkg::ACT_NONE;
          end else if (is_digit) begin
            act = aekd_pkg::ACT_DIGIT;
          end else if (b == aekd_pkg::CH_SEMI) begin
            act = aekd_pkg::ACT_SEP;
          end else if (b == aekd_pkg::CH_TILDE) begin
            act = tilde_lu.hit ? aekd_pkg::ACT_KEY : aekd_pkg::ACT_DROP;
          end else if (key_lu.hit) begin
            act = aekd_pkg::ACT_KEY;
          end else begin
            act = aekd_pkg::ACT_REPLAY;
          end
        end
        default: begin
          if (is_byte) begin
            act = (b == aekd_pkg::ESC_BYTE) ? aekd_pkg::ACT_ESC_START : aekd_pkg::ACT_PASS;
          end
        end
      endcase
    end
  end

  // Parser mode
  always_comb begin
    mode_nxt = mode_r;
    unique case (act)
      aekd_pkg::ACT_ESC_START: mode_nxt = aekd_pkg::MODE_ESC;
      aekd_pkg::ACT_PASS,
      aekd_pkg::ACT_TIMEOUT,
      aekd_pkg::ACT_KEY,
      aekd_pkg::ACT_DROP:      mode_nxt = aekd_pkg::MODE_NORMAL;
      aekd_pkg::ACT_OPEN:      mode_nxt = aekd_pkg::MODE_CSI;
      aekd_pkg::ACT_REPLAY:    mode_nxt = rep_esc ? aekd_pkg::MODE_ESC : aekd_pkg::MODE_NORMAL;
      default:                 mode_nxt = mode_r;
    endcase
  end

  // Datapath and command posting
  always_comb begin
    idle_cnt_nxt  = idle_cnt_r;
    fill_nxt      = fill_r;
    arg_idx_nxt   = arg_idx_r;
    first_arg_nxt = first_arg_r;
    last_byte_nxt = last_byte_r;
    wait_nxt      = wait_r & ~replay_done;
    ram_we        = 1'b0;
    ram_waddr     = fill_r[AW-1:0];
    ram_wdata     = b;
    q_push        = 1'b0;
    q_cmd.kind    = aekd_pkg::CMD_EMIT;
    q_cmd.code    = b;
    q_cmd.has_tail = 1'b0;
    q_last_idx    = cnt_m2[AW-1:0];
    unique case (act)
      aekd_pkg::ACT_ESC_START: begin
        ram_we        = 1'b1;
        ram_waddr     = '0;
        fill_nxt      = CW'(1);
        last_byte_nxt = aekd_pkg::ESC_BYTE;
        idle_cnt_nxt  = 16'd0;
      end
      aekd_pkg::ACT_PASS: begin
        q_push = 1'b1;
      end
      aekd_pkg::ACT_TIMEOUT: begin
        fill_nxt   = '0;
        q_push     = 1'b1;
        q_cmd.code = aekd_pkg::ESC_BYTE;
      end
      aekd_pkg::ACT_TICK: begin
        idle_cnt_nxt = idle_cnt_r + 16'd1;
      end
      aekd_pkg::ACT_OPEN: begin
        ram_we        = room;
        fill_nxt      = fill_eff;
        last_byte_nxt = last_eff;
        arg_idx_nxt   = 3'd0;
        first_arg_nxt = 8'd0;
      end
      aekd_pkg::ACT_DIGIT: begin
        ram_we        = room;
        fill_nxt      = fill_eff;
        last_byte_nxt = last_eff;
        if (arg_idx_r == 3'd0) begin
          first_arg_nxt = (arg_acc > 12'(aekd_pkg::ARG_SAT)) ? aekd_pkg::ARG_SAT
                                                                : arg_acc[7:0];
        end
      end
      aekd_pkg::ACT_SEP: begin
        ram_we        = room;
        fill_nxt      = fill_eff;
        last_byte_nxt = last_eff;
        if (arg_idx_r < aekd_pkg::ARG_INDEX_MAX) begin
          arg_idx_nxt = arg_idx_r + 3'd1;
        end
      end
      aekd_pkg::ACT_KEY: begin
        ram_we     = room;
        fill_nxt   = '0;
        q_push     = 1'b1;
        q_cmd.code = key_code;
      end
      aekd_pkg::ACT_DROP: begin
        ram_we   = room;
        fill_nxt = '0;
      end
      aekd_pkg::ACT_REPLAY: begin
        // raw bytes 0 .. fill-2, then the last stored byte seen afresh
        ram_we         = room;
        q_push         = 1'b1;
        q_cmd.kind     = aekd_pkg::CMD_REPLAY;
        q_cmd.code     = last_eff;
        q_cmd.has_tail = ~rep_esc;
        wait_nxt       = 1'b1;
        if (rep_esc) begin
          // entry 0 already holds ESC
          fill_nxt      = CW'(1);
          idle_cnt_nxt  = 16'd0;
          last_byte_nxt = aekd_pkg::ESC_BYTE;
        end else begin
          fill_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= aekd_pkg::MODE_NORMAL;
      idle_cnt_r  <= 16'd0;
      fill_r      <= '0;
      arg_idx_r   <= 3'd0;
      first_arg_r <= 8'd0;
      wait_r      <= 1'b0;
      timeout_r   <= aekd_pkg::TIMEOUT_RESET;
    end else begin
      mode_r      <= mode_nxt;
      idle_cnt_r  <= idle_cnt_nxt;
      fill_r      <= fill_nxt;
      arg_idx_r   <= arg_idx_nxt;
      first_arg_r <= first_arg_nxt;
      wait_r      <= wait_nxt;
      if (cfg_valid) begin
        timeout_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_byte_r <= last_byte_nxt;
  end

endmodule

`default_nettype wire

>>> src/aekd_back.sv
// Back end: executes commands, reads the sequence buffer for replays and
// holds the result register. Depends on aekd_pkg.
`default_nettype none

module aekd_back #(
  parameter int unsigned BUFFER_DEPTH = 32,
  localparam int unsigned AW = $clog2(BUFFER_DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_empty,
  output logic                      q_pop,
  input  wire aekd_pkg::cmd_t       q_cmd,
  input  wire logic [AW-1:0]        q_last_idx,
  output logic [AW-1:0]             ram_raddr,
  input  wire logic [7:0]           ram_rdata,
  output logic                      replay_done,
  output logic                      empty,
  input  wire logic                 pop,
  output aekd_pkg::out_item_t       out_item
);

  aekd_pkg::back_state_t state_r, state_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [AW-1:0]         last_idx_r, last_idx_nxt;
  logic                  has_tail_r, has_tail_nxt;
  logic [7:0]            code_r, code_nxt;
  logic                  out_valid_r, out_valid_nxt;
  aekd_pkg::out_item_t   out_item_r, load_item;
  logic                  out_free, load, at_end;

  assign empty     = ~out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = ~out_valid_r | pop;
  assign at_end    = (idx_r == last_idx_r);
  // read one ahead so rdata always matches idx_r
  assign ram_raddr = idx_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aekd_pkg::BS_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_cmd.kind == aekd_pkg::CMD_REPLAY) ? aekd_pkg::BS_RUN
                                                            : aekd_pkg::BS_TAIL;
        end
      end
      aekd_pkg::BS_RUN: begin
        if (out_free && at_end) begin
          state_nxt = has_tail_r ? aekd_pkg::BS_TAIL : aekd_pkg::BS_IDLE;
        end
      end
      aekd_pkg::BS_TAIL: begin
        if (out_free) begin
          state_nxt = aekd_pkg::BS_IDLE;
        end
      end
      default: state_nxt = aekd_pkg::BS_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    idx_nxt      = idx_r;
    last_idx_nxt = last_idx_r;
    has_tail_nxt = has_tail_r;
    code_nxt     = code_r;
    load         = 1'b0;
    load_item    = '{key_code: code_r, last_of_run: 1'b1};
    replay_done  = 1'b0;
    unique case (state_r)
      aekd_pkg::BS_IDLE: begin
        idx_nxt = '0;
        if (!q_empty) begin
          q_pop        = 1'b1;
          last_idx_nxt = q_last_idx;
          has_tail_nxt = q_cmd.has_tail;
          code_nxt     = q_cmd.code;
        end
      end
      aekd_pkg::BS_RUN: begin
        if (out_free) begin
          load      = 1'b1;
          load_item = '{key_code: ram_rdata, last_of_run: at_end & ~has_tail_r};
          if (at_end) begin
            replay_done = 1'b1;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end
      aekd_pkg::BS_TAIL: begin
        load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aekd_pkg::BS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    last_idx_r <= last_idx_nxt;
    has_tail_r <= has_tail_nxt;
    code_r     <= code_nxt;
    if (load) begin
      out_item_r <= load_item;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == aekd_pkg::BS_RUN |-> idx_r <= last_idx_r)
    else $error("replay index past last entry");

  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    replay_done |-> (state_r == aekd_pkg::BS_RUN && load))
    else $error("replay done outside a replay load");

  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == aekd_pkg::BS_RUN || state_r == aekd_pkg::BS_TAIL))
    else $error("command popped but back end idle");

endmodule

`default_nettype wire

>>> src/ansi_escape_key_decoder.sv
// A result goes from the command queue through the back end to the result
// register. The back end executes one command at a time; a replay drains the
// buffer at one byte a cycle unless results back up, input held until read out.
// Reset (rst_n low, synchronous): parser to normal mode, queue and result
// register emptied, timeout back to 8000; buffer contents left as they are.
// Depends on aekd_pkg, aekd_ram, aekd_cmdq, aekd_front, aekd_back.
`default_nettype none

module ansi_escape_key_decoder #(
  parameter int unsigned BUFFER_DEPTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input beats: byte or idle tick
  input  wire logic                push,
  output logic                     full,
  input  wire aekd_pkg::in_item_t  in_item,
  // results
  output logic                     empty,
  input  wire logic                pop,
  output aekd_pkg::out_item_t      out_item,
  // escape timeout register
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [15:0]         cfg_data
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned QW = $bits(aekd_pkg::cmd_t) + AW;

  // Buffer write side (front) and read side (back)
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // Command queue
  logic           q_push, q_full, q_pop, q_empty;
  aekd_pkg::cmd_t f_cmd, b_cmd;
  logic [AW-1:0]  f_last_idx, b_last_idx;
  logic [QW-1:0]  q_wdata, q_rdata;

  logic replay_done;

  // Front: parser state, timeout register, buffer writes. It holds full
  // while a replay is in flight so the buffer is not overwritten under the
  // back end's reads.
  aekd_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_item     (in_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .q_push      (q_push),
    .q_full      (q_full),
    .q_cmd       (f_cmd),
    .q_last_idx  (f_last_idx),
    .replay_done (replay_done)
  );

  assign q_wdata = {f_cmd, f_last_idx};

  // Short queue parting front and back
  aekd_cmdq #(.W(QW)) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign b_cmd      = aekd_pkg::cmd_t'(q_rdata[QW-1:AW]);
  assign b_last_idx = q_rdata[AW-1:0];

  // Sequence buffer: written by the front, read by the back during replay
  aekd_ram #(.W(8), .DEPTH(BUFFER_DEPTH)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Back: command execution and result register
  aekd_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_cmd       (b_cmd),
    .q_last_idx  (b_last_idx),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .replay_done (replay_done),
    .empty       (empty),
    .pop         (pop),
    .out_item    (out_item)
  );

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking bench for ansi_escape_key_decoder: keypad scoreboard class with
// its own decoder state, queue-style drivers and a random result-side stall.
// Depends on aekd_pkg and the decoder RTL only.
`default_nettype none

module tb;
  import aekd_pkg::*;

  localparam int unsigned BUF_DEPTH     = 32;
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int unsigned HOLD_CYCLES   = 400;   // long result-side hold-off
  localparam int unsigned SETTLE_CYCLES = 8;     // settle time once no results are expected
  localparam logic [8:0]  NO_KEY        = 9'h100;

  // Keypad scoreboard: tracks the decoder's parse state and queues the key
  // codes each accepted beat should produce.
  class keypad_scoreboard;
    logic [15:0] timeout_ticks;
    mode_t       mode;
    int unsigned idle_ticks;
    logic [7:0]  seq_buf [BUF_DEPTH];
    int unsigned fill;
    int unsigned arg_idx;
    int unsigned arg0;
    logic [7:0]  run_codes [$];
    out_item_t   expected_keys [$];
    int unsigned errors;

    function new();
      timeout_ticks = TIMEOUT_RESET;
      mode          = MODE_NORMAL;
      idle_ticks    = 0;
      fill          = 0;
      arg_idx       = 0;
      arg0          = 0;
      errors        = 0;
    endfunction

    function void store(logic [7:0] b);
      if (fill < BUF_DEPTH) begin
        seq_buf[fill] = b;
        fill++;
      end
    endfunction

    function void fresh(logic [7:0] b);
      if (b == ESC_BYTE) begin
        fill = 0;
        store(b);
        idle_ticks = 0;
        mode = MODE_ESC;
      end else begin
        mode = MODE_NORMAL;
        run_codes.push_back(b);
      end
    endfunction

    // raw bytes out, last one goes back through the normal-mode path
    function void replay();
      logic [7:0] tail;
      if (fill == 0) begin
        mode = MODE_NORMAL;
        return;
      end
      for (int i = 0; i + 1 < fill; i++) run_codes.push_back(seq_buf[i]);
      tail = seq_buf[fill-1];
      fill = 0;
      mode = MODE_NORMAL;
      fresh(tail);
    endfunction

    function logic [8:0] letter_code_of(logic [7:0] b);
      case (b)
        CH_A: return {1'b0, KEY_UP};
        CH_B: return {1'b0, KEY_DOWN};
        CH_C: return {1'b0, KEY_RIGHT};
        CH_D: return {1'b0, KEY_LEFT};
        CH_H: return {1'b0, KEY_HOME};
        CH_F: return {1'b0, KEY_END};
        default: return NO_KEY;
      endcase
    endfunction

    function logic [8:0] tilde_code_of(int unsigned a);
      case (a)
        1, 7: return {1'b0, KEY_HOME};
        2:    return {1'b0, KEY_INS};
        3:    return {1'b0, KEY_DEL};
        4, 8: return {1'b0, KEY_END};
        5:    return {1'b0, KEY_PGUP};
        6:    return {1'b0, KEY_PGDN};
        default: return NO_KEY;
      endcase
    endfunction

    function void note_beat(in_item_t it);
      logic [7:0]  b;
      logic [8:0]  key;
      int unsigned v;
      b = it.byte_value;
      run_codes.delete();
      if (it.operation == OP_IDLE) begin
        if (mode == MODE_ESC) begin
          if (idle_ticks >= timeout_ticks) begin
            fill = 0;
            mode = MODE_NORMAL;
            run_codes.push_back(ESC_BYTE);
          end else begin
            idle_ticks++;
          end
        end
      end else if (mode == MODE_NORMAL) begin
        fresh(b);
      end else if (mode == MODE_ESC) begin
        store(b);
        if (b == CH_LBRACK || b == CH_SS3) begin
          arg_idx = 0;
          arg0 = 0;
          mode = MODE_CSI;
        end else begin
          replay();
        end
      end else if (b >= CH_0 && b <= CH_9) begin
        store(b);
        if (arg_idx == 0) begin
          v = arg0 * 10 + (b - CH_0);
          arg0 = (v > ARG_SAT) ? ARG_SAT : v;
        end
      end else if (b == CH_SEMI) begin
        store(b);
        if (arg_idx < ARG_INDEX_MAX) arg_idx++;
      end else begin
        store(b);
        if (b == CH_TILDE) begin
          fill = 0;
          mode = MODE_NORMAL;
          key = tilde_code_of(arg0);
          if (!key[8]) run_codes.push_back(key[7:0]);
        end else begin
          key = letter_code_of(b);
          if (!key[8]) begin
            fill = 0;
            mode = MODE_NORMAL;
            run_codes.push_back(key[7:0]);
          end else begin
            replay();
          end
        end
      end
      foreach (run_codes[i])
        expected_keys.push_back('{key_code: run_codes[i],
                                  last_of_run: (i == run_codes.size() - 1)});
    endfunction

    function void check_key(out_item_t got);
      out_item_t want;
      if (expected_keys.size() == 0) begin
        $display("%0t: result with none expected: key_code %02h last_of_run %b",
                 $time, got.key_code, got.last_of_run);
        errors++;
        return;
      end
      want = expected_keys.pop_front();
      if (got.key_code !== want.key_code) begin
        $display("%0t: key_code expected %02h actual %02h",
                 $time, want.key_code, got.key_code);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $display("%0t: last_of_run expected %b actual %b",
                 $time, want.last_of_run, got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  in_item_t    in_item;
  logic        empty;
  logic        pop;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  keypad_scoreboard keys = new();
  bit          quiet    = 1'b0;  // set for the closing phase: no idling either side
  bit          hold_req = 1'b0;  // asks the result side for one long hold-off
  int unsigned beats_sent = 0;
  int unsigned cycles     = 0;

  ansi_escape_key_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ansi_escape_key_decoder verification failed");
      $finish;
    end
  end

  // Result side. Everything is sampled at the rising edge (pre-edge values) and
  // pop is updated by a single nonblocking assignment per edge. Random stall
  // bursts, plus one long hold-off on request.
  initial begin : result_side
    int unsigned stall_left;
    stall_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && empty === 1'b0) keys.check_key(out_item);
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (!rst_n) begin
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(0, 10);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic in_item_t byte_item(logic [7:0] b);
    return '{operation: OP_BYTE, byte_value: b};
  endfunction

  // byte lane is ignored on an idle tick, so fill it with noise
  function automatic in_item_t idle_item();
    return '{operation: OP_IDLE, byte_value: 8'($urandom_range(0, 255))};
  endfunction

  // One input beat. An optional gap goes before it; push stays high from one
  // beat to the next when there is no gap, so it is never lowered and raised
  // in the same time step.
  task automatic send_item(input in_item_t it, input bit may_idle);
    if (may_idle && !quiet && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    keys.note_beat(it);
    beats_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(byte_item(b), 1'b1);
  endtask

  task automatic send_idle();
    send_item(idle_item(), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Timeout register: only written with the decoder drained and settled.
  task automatic write_timeout(input logic [15:0] ticks);
    push <= 1'b0;
    while (keys.expected_keys.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    keys.timeout_ticks = ticks;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == ESC_BYTE) ? ~ESC_BYTE : b;
  endfunction

  function automatic logic [7:0] arg_byte();
    return ($urandom_range(0, 4) == 0) ? CH_SEMI : CH_0 + 8'($urandom_range(0, 9));
  endfunction

  // Random traffic, mostly well-formed escape sequences with random content,
  // the rest plain bytes, idle ticks and broken sequences.
  task automatic send_random_traffic(input int unsigned n_beats);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  letters [6];
    letters = '{CH_A, CH_B, CH_C, CH_D, CH_H, CH_F};
    start = beats_sent;
    while (beats_sent - start < n_beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 20) begin
        send_idle();
      end else if (pick < 30) begin
        // lone ESC, idle ticks (around the timeout when it is at most 16)
        send_byte(ESC_BYTE);
        len = (keys.timeout_ticks <= 16) ? $urandom_range(0, keys.timeout_ticks + 2)
                                         : $urandom_range(0, 4);
        repeat (len) send_idle();
        if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 75) begin
        send_byte(ESC_BYTE);
        send_byte($urandom_range(0, 1) ? CH_LBRACK : CH_SS3);
        repeat ($urandom_range(0, 3)) send_byte(CH_0 + 8'($urandom_range(0, 9)));
        repeat ($urandom_range(0, 2)) begin
          send_byte(CH_SEMI);
          repeat ($urandom_range(0, 2)) send_byte(arg_byte());
        end
        if ($urandom_range(0, 9) == 0) send_idle();
        pick = $urandom_range(0, 9);
        if (pick < 6)      send_byte(letters[$urandom_range(0, 5)]);
        else if (pick < 8) send_byte(CH_TILDE);
        else               send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 85) begin
        send_byte(ESC_BYTE);
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
        // long sequence, may overrun the buffer before its final byte
        send_byte(ESC_BYTE);
        send_byte(CH_LBRACK);
        repeat ($urandom_range(28, 40)) send_byte(arg_byte());
        send_byte($urandom_range(0, 1) ? letters[$urandom_range(0, 5)] : 8'h5a);
      end else begin
        case ($urandom_range(0, 4))
          0: send_byte(ESC_BYTE);
          1: send_byte(CH_LBRACK);
          2: send_byte(CH_SS3);
          3: send_byte(CH_TILDE);
          default: send_byte(CH_SEMI);
        endcase
      end
    end
  endtask

  initial begin : stimulus
    string intro;
    string finals;
    finals    = "ABCDHF";
    rst_n     <= 1'b0;
    push      <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes, idle tick in normal mode, a lone ESC held well
    // short of the reset timeout and then replayed by a plain byte.
    send_byte(8'h00);
    send_byte(8'hff);
    send_idle();
    send_byte(ESC_BYTE);
    repeat (6) send_item(idle_item(), 1'b0);
    send_byte(8'h78);

    // timeout zero: first idle tick after ESC lets it through
    write_timeout(16'd0);
    send_byte(ESC_BYTE);
    send_idle();

    // every final letter, both introducers
    for (int i = 0; i < 6; i++) begin
      intro = (i % 2) ? "O" : "[";
      send_byte(ESC_BYTE);
      send_text(intro);
      send_byte(finals[i]);
    end
    // tilde with every mapped argument, then unknown ones (dropped)
    for (int d = 1; d <= 9; d++) begin
      send_byte(ESC_BYTE);
      send_byte(CH_LBRACK);
      send_byte(CH_0 + 8'(d));
      send_byte(CH_TILDE);
    end
    send_byte(ESC_BYTE); send_text("[0~");
    send_byte(ESC_BYTE); send_text("[999~");       // argument saturates
    send_byte(ESC_BYTE); send_text("[2;5~");       // later arguments ignored
    send_byte(ESC_BYTE); send_text("[;;;;;;;;;A"); // separator count saturates
    send_byte(ESC_BYTE); send_text("[12;3Z");      // unknown final: replay
    send_byte(ESC_BYTE); send_text("x");           // replay after ESC
    send_byte(ESC_BYTE); send_byte(ESC_BYTE);      // replay tail reopens an escape
    send_idle();
    send_byte(ESC_BYTE); send_text("[1");          // idle ticks inside a sequence
    send_idle();
    send_idle();
    send_text("A");
    send_byte(ESC_BYTE); send_text("[");           // buffer overrun, then replay
    repeat (40) send_byte(CH_0 + 8'($urandom_range(0, 9)));
    send_text("Z");

    // Random phase with the long result-side hold-off: the decoder backs up
    // and stalls its input while plain bytes keep being offered.
    write_timeout(16'd2);
    hold_req = 1'b1;
    repeat (48) send_item(byte_item(plain_byte()), 1'b0);
    send_random_traffic(20);

    // Timeout at its top value: a few ticks leave the ESC pending.
    write_timeout(16'hffff);
    send_byte(ESC_BYTE);
    repeat (6) send_item(idle_item(), 1'b0);
    send_random_traffic(25);

    write_timeout(16'($urandom_range(3, 65534)));
    send_random_traffic(25);

    // closing phase: no idling on either side
    write_timeout(16'd1);
    quiet = 1'b1;
    send_random_traffic(30);

    push <= 1'b0;
    while (keys.expected_keys.size() != 0) @(posedge clk);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (keys.errors == 0 && keys.expected_keys.size() == 0) begin
      $display("ansi_escape_key_decoder verification clean");
    end else begin
      $display("ansi_escape_key_decoder verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
src/aekd_pkg.sv
src/aekd_ram.sv
src/aekd_cmdq.sv
src/aekd_front.sv
src/aekd_back.sv
src/ansi_escape_key_decoder.sv
tb/tb.sv
